// ----- design/xsrng_pkg.sv -----
// Shared types, constants and helper functions of the xorshift64* bounded generator.
package xsrng_pkg;

    localparam int WORD_W  = 64;
    localparam int BOUND_W = 32;
    localparam int MODE_W  = 2;
    localparam int STEP_W  = $clog2(WORD_W);

    // Request selector codes
    localparam logic [MODE_W-1:0] MODE_RAW   = 2'd0;
    localparam logic [MODE_W-1:0] MODE_UPPER = 2'd1;
    localparam logic [MODE_W-1:0] MODE_RANGE = 2'd2;

    localparam logic [WORD_W-1:0] MIX_MUL_A = 64'hff51afd7ed558ccd;
    localparam logic [WORD_W-1:0] MIX_MUL_B = 64'hc4ceb9fe1a85ec53;
    localparam logic [WORD_W-1:0] GOLDEN    = 64'h9e3779b97f4a7c15;
    localparam logic [WORD_W-1:0] STAR_MUL  = 64'h2545f4914f6cdd1d;

    typedef struct packed {
        logic              start;
        logic [WORD_W-1:0] multiplicand;
        logic [WORD_W-1:0] multiplier;
    } t_mul_req;

    typedef struct packed {
        logic              done;
        logic [WORD_W-1:0] product;
    } t_mul_rsp;

    typedef struct packed {
        logic               start;
        logic [WORD_W-1:0]  dividend;
        logic [BOUND_W-1:0] divisor;
    } t_div_req;

    typedef struct packed {
        logic               done;
        logic [BOUND_W-1:0] remainder;
    } t_div_rsp;

    // Fold the upper bits (from bit 33 up) into the low bits, as done around each finalizer multiply
    function automatic logic [WORD_W-1:0] fold33(input logic [WORD_W-1:0] v);
        return v ^ (v >> 33);
    endfunction

    // One xorshift advance of the generator state
    function automatic logic [WORD_W-1:0] xorshift(input logic [WORD_W-1:0] s);
        logic [WORD_W-1:0] t;
        t = s ^ (s >> 12);
        t = t ^ (t << 25);
        t = t ^ (t >> 27);
        return t;
    endfunction

    // Full finalizer mix; evaluated only for constants at elaboration
    function automatic logic [WORD_W-1:0] mix_const(input logic [WORD_W-1:0] v);
        logic [WORD_W-1:0] t;
        t = fold33(v);
        t = t * MIX_MUL_A;
        t = fold33(t);
        t = t * MIX_MUL_B;
        t = fold33(t);
        return (t == '0) ? GOLDEN : t;
    endfunction

    localparam logic [WORD_W-1:0] RESET_STATE = mix_const(64'd1);

endpackage

// ----- design/xsrng_req_if.sv -----
// Request channel: selector and bound of one draw.
interface xsrng_req_if;
    logic                             valid;
    logic                             ready;
    logic [xsrng_pkg::MODE_W-1:0]     mode;
    logic [xsrng_pkg::BOUND_W-1:0]    upper_bound;

    modport source (output valid, output mode, output upper_bound, input ready);
    modport sink   (input valid, input mode, input upper_bound, output ready);
endinterface

// ----- design/xsrng_rsp_if.sv -----
// Response channel: one random value per request.
interface xsrng_rsp_if;
    logic                          valid;
    logic                          ready;
    logic [xsrng_pkg::WORD_W-1:0]  value;

    modport source (output valid, output value, input ready);
    modport sink   (input valid, input value, output ready);
endinterface

// ----- design/xsrng_cfg_if.sv -----
// Configuration channel: seed register write.
interface xsrng_cfg_if;
    logic                          valid;
    logic                          ready;
    logic [xsrng_pkg::WORD_W-1:0]  seed;

    modport source (output valid, output seed, input ready);
    modport sink   (input valid, input seed, output ready);
endinterface

// ----- design/xsrng_mul.sv -----
// Bit-serial shift-and-add multiplier giving the low 64 bits of a product.
module xsrng_mul (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  xsrng_pkg::t_mul_req i_req,
    output xsrng_pkg::t_mul_rsp o_rsp
);

    logic                           r_busy;
    logic                           r_done;
    logic [xsrng_pkg::WORD_W-1:0]   r_a;
    logic [xsrng_pkg::WORD_W-1:0]   r_b;
    logic [xsrng_pkg::WORD_W-1:0]   r_acc;
    logic [xsrng_pkg::STEP_W-1:0]   r_cnt;

    // Consume one multiplier bit per cycle, low bit first
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_a    <= i_req.multiplicand;
                r_b    <= i_req.multiplier;
                r_acc  <= '0;
                r_cnt  <= '0;
                r_busy <= 1'b1;
            end else if (r_busy) begin
                if (r_b[0]) begin
                    r_acc <= r_acc + r_a;
                end
                r_a   <= r_a << 1;
                r_b   <= r_b >> 1;
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == xsrng_pkg::STEP_W'(xsrng_pkg::WORD_W - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_rsp = '{done: r_done, product: r_acc};

endmodule

// ----- design/xsrng_div.sv -----
// Bit-serial restoring remainder unit: 64-bit dividend modulo a 32-bit divisor.
module xsrng_div (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  xsrng_pkg::t_div_req i_req,
    output xsrng_pkg::t_div_rsp o_rsp
);

    logic                           r_busy;
    logic                           r_done;
    logic [xsrng_pkg::WORD_W-1:0]   r_dvd;
    logic [xsrng_pkg::BOUND_W-1:0]  r_dsr;
    logic [xsrng_pkg::BOUND_W-1:0]  r_rem;
    logic [xsrng_pkg::STEP_W-1:0]   r_cnt;

    logic [xsrng_pkg::BOUND_W:0]    w_trial;
    logic [xsrng_pkg::BOUND_W:0]    w_diff;
    logic                           w_fits;

    // Bring down the next dividend bit and try one subtract
    assign w_trial = {r_rem, r_dvd[xsrng_pkg::WORD_W-1]};
    assign w_diff  = w_trial - {1'b0, r_dsr};
    assign w_fits  = (w_trial >= {1'b0, r_dsr});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_dvd  <= i_req.dividend;
                r_dsr  <= i_req.divisor;
                r_rem  <= '0;
                r_cnt  <= '0;
                r_busy <= 1'b1;
            end else if (r_busy) begin
                r_rem <= w_fits ? w_diff[xsrng_pkg::BOUND_W-1:0]
                                : w_trial[xsrng_pkg::BOUND_W-1:0];
                r_dvd <= r_dvd << 1;
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == xsrng_pkg::STEP_W'(xsrng_pkg::WORD_W - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_rsp = '{done: r_done, remainder: r_rem};

endmodule

// ----- design/xorshift64star_bounded_rng.sv -----
// Xorshift64* generator with raw, upper-half and bounded draws. One request is
// handled at a time. A raw or upper-half draw runs one bit-serial multiply by
// the star constant. A bounded draw first runs a serial remainder for the
// rejection threshold, then one draw plus up to RETRY_LIMIT retries, and a
// final serial remainder. A zero bound or the unused selector answers with zero
// and runs neither unit. A seed write runs two serial multiplies and holds off
// requests meanwhile. The finished result sits in an output register, so the
// next request is taken while it waits.
module xorshift64star_bounded_rng #(
    parameter int RETRY_LIMIT = 16
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    xsrng_cfg_if.sink         i_cfg,
    xsrng_req_if.sink         i_req,
    xsrng_rsp_if.source       o_rsp
);

    localparam int TRY_W = $clog2(RETRY_LIMIT + 1);
    localparam int W     = xsrng_pkg::WORD_W;
    localparam int BW    = xsrng_pkg::BOUND_W;

    typedef enum logic [3:0] {
        S_IDLE,
        S_MIX_A,
        S_MIX_B,
        S_LIMIT,
        S_DRAW,
        S_DRAW_WAIT,
        S_REDUCE,
        S_DONE
    } t_fsm;

    t_fsm                          r_fsm;
    logic [W-1:0]                  r_gen;
    logic [xsrng_pkg::MODE_W-1:0]  r_mode;
    logic [BW-1:0]                 r_bound;
    logic [BW-1:0]                 r_limit;
    logic [TRY_W-1:0]              r_tries;
    logic [W-1:0]                  r_result;
    logic                          r_out_valid;
    logic [W-1:0]                  r_out_value;
    xsrng_pkg::t_mul_req           r_mul_req;
    xsrng_pkg::t_div_req           r_div_req;

    xsrng_pkg::t_mul_rsp           mul_rsp;
    xsrng_pkg::t_div_rsp           div_rsp;
    logic [W-1:0]                  w_next_gen;
    logic [W-1:0]                  w_mix_out;
    logic [W-1:0]                  w_raw;

    xsrng_mul u_mul (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (r_mul_req),
        .o_rsp   (mul_rsp)
    );

    xsrng_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (r_div_req),
        .o_rsp   (div_rsp)
    );

    assign w_next_gen = xsrng_pkg::xorshift(r_gen);
    assign w_mix_out  = xsrng_pkg::fold33(mul_rsp.product);
    assign w_raw      = mul_rsp.product;

    // Take a seed write or a request only between transactions
    assign i_cfg.ready = (r_fsm == S_IDLE);
    assign i_req.ready = (r_fsm == S_IDLE) && !i_cfg.valid;
    assign o_rsp.valid = r_out_valid;
    assign o_rsp.value = r_out_value;

    // Sequencer, generator state and result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fsm           <= S_IDLE;
            r_gen           <= xsrng_pkg::RESET_STATE;
            r_tries         <= '0;
            r_out_valid     <= 1'b0;
            r_mul_req.start <= 1'b0;
            r_div_req.start <= 1'b0;
        end else begin
            // Drop the held result once taken, unless a new one replaces it
            if (o_rsp.valid && o_rsp.ready && r_fsm != S_DONE) begin
                r_out_valid <= 1'b0;
            end
            case (r_fsm)
                S_IDLE: begin
                    if (i_cfg.valid) begin
                        r_mul_req <= '{start: 1'b1,
                                       multiplicand: xsrng_pkg::fold33(i_cfg.seed),
                                       multiplier: xsrng_pkg::MIX_MUL_A};
                        r_fsm     <= S_MIX_A;
                    end else if (i_req.valid) begin
                        r_mode  <= i_req.mode;
                        r_bound <= i_req.upper_bound;
                        r_tries <= '0;
                        if (i_req.mode == xsrng_pkg::MODE_RAW ||
                            i_req.mode == xsrng_pkg::MODE_UPPER) begin
                            r_fsm <= S_DRAW;
                        end else if (i_req.mode == xsrng_pkg::MODE_RANGE &&
                                     i_req.upper_bound != '0) begin
                            // Threshold is (2^64 - bound) mod bound
                            r_div_req <= '{start: 1'b1,
                                           dividend: {{BW{1'b1}}, -i_req.upper_bound},
                                           divisor: i_req.upper_bound};
                            r_fsm     <= S_LIMIT;
                        end else begin
                            r_result <= '0;
                            r_fsm    <= S_DONE;
                        end
                    end
                end
                S_MIX_A: begin
                    if (mul_rsp.done) begin
                        r_mul_req <= '{start: 1'b1,
                                       multiplicand: w_mix_out,
                                       multiplier: xsrng_pkg::MIX_MUL_B};
                        r_fsm     <= S_MIX_B;
                    end else begin
                        r_mul_req.start <= 1'b0;
                    end
                end
                S_MIX_B: begin
                    if (mul_rsp.done) begin
                        r_gen <= (w_mix_out == '0) ? xsrng_pkg::GOLDEN : w_mix_out;
                        r_fsm <= S_IDLE;
                    end else begin
                        r_mul_req.start <= 1'b0;
                    end
                end
                S_LIMIT: begin
                    if (div_rsp.done) begin
                        r_limit <= div_rsp.remainder;
                        r_fsm   <= S_DRAW;
                    end else begin
                        r_div_req.start <= 1'b0;
                    end
                end
                S_DRAW: begin
                    // Advance the state and scramble it with the star multiply
                    r_gen     <= w_next_gen;
                    r_mul_req <= '{start: 1'b1,
                                   multiplicand: w_next_gen,
                                   multiplier: xsrng_pkg::STAR_MUL};
                    r_fsm     <= S_DRAW_WAIT;
                end
                S_DRAW_WAIT: begin
                    if (mul_rsp.done) begin
                        if (r_mode == xsrng_pkg::MODE_RAW) begin
                            r_result <= w_raw;
                            r_fsm    <= S_DONE;
                        end else if (r_mode == xsrng_pkg::MODE_UPPER) begin
                            r_result <= {{(W-BW){1'b0}}, w_raw[W-1:W-BW]};
                            r_fsm    <= S_DONE;
                        end else if (r_tries == TRY_W'(RETRY_LIMIT) ||
                                     w_raw >= {{(W-BW){1'b0}}, r_limit}) begin
                            // Accept the draw, or take it unchecked once retries run out
                            r_div_req <= '{start: 1'b1, dividend: w_raw, divisor: r_bound};
                            r_fsm     <= S_REDUCE;
                        end else begin
                            r_tries <= r_tries + 1'b1;
                            r_fsm   <= S_DRAW;
                        end
                    end else begin
                        r_mul_req.start <= 1'b0;
                    end
                end
                S_REDUCE: begin
                    if (div_rsp.done) begin
                        r_result <= {{(W-BW){1'b0}}, div_rsp.remainder};
                        r_fsm    <= S_DONE;
                    end else begin
                        r_div_req.start <= 1'b0;
                    end
                end
                S_DONE: begin
                    // Hand over once the output register is free
                    if (!r_out_valid || o_rsp.ready) begin
                        r_out_value <= r_result;
                        r_out_valid <= 1'b1;
                        r_fsm       <= S_IDLE;
                    end
                end
                default: begin
                    r_fsm <= S_IDLE;
                end
            endcase
        end
    end

    a_state_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_gen != '0)
        else $error("generator state reached zero");

    a_retry_bounded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_tries <= TRY_W'(RETRY_LIMIT))
        else $error("retry count past limit");

    a_range_below: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_fsm == S_DONE && r_mode == xsrng_pkg::MODE_RANGE && r_bound != '0)
        |-> (r_result < {{(W-BW){1'b0}}, r_bound}))
        else $error("bounded result not below bound");

    a_accept_leaves_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_req.valid && i_req.ready) |=> (r_fsm != S_IDLE))
        else $error("accepted transaction did not start work");

    a_mul_done_expected: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        mul_rsp.done |-> (r_fsm == S_MIX_A || r_fsm == S_MIX_B || r_fsm == S_DRAW_WAIT))
        else $error("multiplier finished with no waiting step");

endmodule

// ----- dv/xsrng_checker.sv -----
// Checker for the xorshift64* bounded generator: predicts each response and compares it.
module xsrng_checker #(
    parameter int RETRY_LIMIT = 16
) (
    input  logic  i_clk,
    input  logic  i_rst_n,
    xsrng_cfg_if  i_cfg,
    xsrng_req_if  i_req,
    xsrng_rsp_if  i_rsp,
    output int    o_fail_count,
    output int    o_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    logic [xsrng_pkg::WORD_W-1:0] seed_reg;
    logic [xsrng_pkg::WORD_W-1:0] gen_word;
    logic [xsrng_pkg::WORD_W-1:0] expected_values[$];
    int                           fails = 0;

    assign o_fail_count = fails;

    // Scramble a seed into a starting state; an all-zero state is not allowed
    function automatic logic [xsrng_pkg::WORD_W-1:0] seed_scramble(
        input logic [xsrng_pkg::WORD_W-1:0] s);
        logic [xsrng_pkg::WORD_W-1:0] v;
        v = s ^ (s >> 33);
        v = v * xsrng_pkg::MIX_MUL_A;
        v = v ^ (v >> 33);
        v = v * xsrng_pkg::MIX_MUL_B;
        v = v ^ (v >> 33);
        if (v == '0) begin
            v = xsrng_pkg::GOLDEN;
        end
        return v;
    endfunction

    // Advance the state one xorshift step and return the starred output
    function automatic logic [xsrng_pkg::WORD_W-1:0] next_draw();
        gen_word = gen_word ^ (gen_word >> 12);
        gen_word = gen_word ^ (gen_word << 25);
        gen_word = gen_word ^ (gen_word >> 27);
        return gen_word * xsrng_pkg::STAR_MUL;
    endfunction

    // Unbiased draw below the bound, falling back to a plain modulo after the retries
    function automatic logic [xsrng_pkg::WORD_W-1:0] draw_below(
        input logic [xsrng_pkg::BOUND_W-1:0] bound);
        logic [xsrng_pkg::WORD_W-1:0] modulus;
        logic [xsrng_pkg::WORD_W-1:0] reject_floor;
        logic [xsrng_pkg::WORD_W-1:0] raw;
        if (bound == '0) begin
            return '0;
        end
        modulus      = {{(xsrng_pkg::WORD_W-xsrng_pkg::BOUND_W){1'b0}}, bound};
        reject_floor = (xsrng_pkg::WORD_W'(0) - modulus) % modulus;
        for (int tries = 0; tries < RETRY_LIMIT; tries++) begin
            raw = next_draw();
            if (raw >= reject_floor) begin
                return raw % modulus;
            end
        end
        return next_draw() % modulus;
    endfunction

    function automatic logic [xsrng_pkg::WORD_W-1:0] predict_value(
        input logic [xsrng_pkg::MODE_W-1:0]  mode,
        input logic [xsrng_pkg::BOUND_W-1:0] bound);
        logic [xsrng_pkg::WORD_W-1:0] result;
        case (mode)
            xsrng_pkg::MODE_RAW:   result = next_draw();
            xsrng_pkg::MODE_UPPER: result = next_draw() >> 32;
            xsrng_pkg::MODE_RANGE: result = draw_below(bound);
            default:               result = '0;
        endcase
        return result;
    endfunction

    always @(posedge i_clk) begin
        logic [xsrng_pkg::WORD_W-1:0] want;
        if (!i_rst_n) begin
            seed_reg = xsrng_pkg::WORD_W'(1);
            gen_word = seed_scramble(seed_reg);
            expected_values.delete();
        end else begin
            // Compare each returned value with the oldest prediction
            if (i_rsp.valid && i_rsp.ready) begin
                if (expected_values.size() == 0) begin
                    fails++;
                    $error("value: unexpected transaction, actual %h", i_rsp.value);
                end else begin
                    want = expected_values.pop_front();
                    if (i_rsp.value !== want) begin
                        fails++;
                        $error("value: expected %h, actual %h", want, i_rsp.value);
                    end
                end
            end
            // Reload the state on a seed write
            if (i_cfg.valid && i_cfg.ready) begin
                seed_reg = i_cfg.seed;
                gen_word = seed_scramble(seed_reg);
            end
            // Predict the response of each accepted request
            if (i_req.valid && i_req.ready) begin
                expected_values.push_back(predict_value(i_req.mode, i_req.upper_bound));
            end
        end
        o_pending <= expected_values.size();
    end

endmodule

// ----- dv/tb.sv -----
// Testbench top: drives seed writes and draw requests, paces responses, gives the verdict.
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int RETRY_LIMIT  = 16;
    localparam int IDLE_LIMIT   = 16000;
    localparam int HOLD_CYCLES  = 3000;
    localparam int PHASES       = 6;
    localparam int PHASE_ITEMS  = 150;
    localparam int TAIL_CYCLES  = 400;
    localparam logic [xsrng_pkg::MODE_W-1:0] MODE_SPARE = 2'd3;

    logic clk;
    logic rst_n;
    bit   steady;
    bit   hold_go;
    int   fail_count;
    int   pending;

    xsrng_cfg_if cfg_ch ();
    xsrng_req_if req_ch ();
    xsrng_rsp_if rsp_ch ();

    xorshift64star_bounded_rng #(
        .RETRY_LIMIT (RETRY_LIMIT)
    ) u_top (
        .i_clk   (clk),
        .i_rst_n (rst_n),
        .i_cfg   (cfg_ch),
        .i_req   (req_ch),
        .o_rsp   (rsp_ch)
    );

    xsrng_checker #(
        .RETRY_LIMIT (RETRY_LIMIT)
    ) u_checker (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_cfg        (cfg_ch),
        .i_req        (req_ch),
        .i_rsp        (rsp_ch),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    initial begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    // Gap length: mostly none or short, a few long; none in steady phases
    function automatic int idle_len();
        int r;
        if (steady) begin
            return 0;
        end
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 85) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 20);
        return $urandom_range(40, 200);
    endfunction

    task automatic write_seed(input logic [xsrng_pkg::WORD_W-1:0] value);
        cfg_ch.valid <= 1'b1;
        cfg_ch.seed  <= value;
        do @(posedge clk); while (!cfg_ch.ready);
        cfg_ch.valid <= 1'b0;
    endtask

    // Offer one request; valid stays high into the next one when there is no gap
    task automatic send_item(input logic [xsrng_pkg::MODE_W-1:0]  mode,
                             input logic [xsrng_pkg::BOUND_W-1:0] bound);
        int gap;
        gap = idle_len();
        if (gap > 0) begin
            req_ch.valid       <= 1'b0;
            req_ch.mode        <= xsrng_pkg::MODE_W'($urandom);
            req_ch.upper_bound <= $urandom;
            repeat (gap) @(posedge clk);
        end
        req_ch.valid       <= 1'b1;
        req_ch.mode        <= mode;
        req_ch.upper_bound <= bound;
        do @(posedge clk); while (!req_ch.ready);
    endtask

    // Drop valid and hold until every predicted response has come back
    task automatic await_results();
        req_ch.valid <= 1'b0;
        do @(posedge clk); while (pending != 0);
    endtask

    // Response side: random stalls, plus one long hold-off while requests keep coming
    initial begin
        int stall;
        bit held;
        held = 1'b0;
        rsp_ch.ready <= 1'b0;
        do @(posedge clk); while (!rst_n);
        forever begin
            if (hold_go && !held) begin
                held = 1'b1;
                rsp_ch.ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
            end else begin
                stall = idle_len();
                if (stall > 0) begin
                    rsp_ch.ready <= 1'b0;
                    repeat (stall) @(posedge clk);
                end
            end
            rsp_ch.ready <= 1'b1;
            do @(posedge clk); while (!rsp_ch.valid);
        end
    end

    // Watchdog: end the run when nothing moves for too long
    initial begin
        int quiet;
        quiet = 0;
        while (quiet < IDLE_LIMIT) begin
            @(posedge clk);
            if (!rst_n || (cfg_ch.valid && cfg_ch.ready) || (req_ch.valid && req_ch.ready)
                    || (rsp_ch.valid && rsp_ch.ready)) begin
                quiet = 0;
            end else begin
                quiet++;
            end
        end
        $error("watchdog: no transaction for %0d cycles", IDLE_LIMIT);
        $display("** xorshift64star_bounded_rng: FAILED **");
        $finish;
    end

    initial begin
        logic [xsrng_pkg::WORD_W-1:0]  seed_val;
        logic [xsrng_pkg::MODE_W-1:0]  mode_sel;
        logic [xsrng_pkg::BOUND_W-1:0] bound_sel;
        int                            r;

        rst_n              <= 1'b0;
        steady             <= 1'b0;
        hold_go            <= 1'b0;
        cfg_ch.valid       <= 1'b0;
        cfg_ch.seed        <= '0;
        req_ch.valid       <= 1'b0;
        req_ch.mode        <= xsrng_pkg::MODE_RAW;
        req_ch.upper_bound <= '0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        // Reset seed: field extremes, every selector, zero bound, unused selector
        send_item(xsrng_pkg::MODE_RAW, '0);
        send_item(xsrng_pkg::MODE_RAW, '1);
        send_item(xsrng_pkg::MODE_UPPER, '0);
        send_item(xsrng_pkg::MODE_UPPER, '1);
        send_item(xsrng_pkg::MODE_RANGE, '0);
        send_item(xsrng_pkg::MODE_RANGE, 32'd1);
        send_item(xsrng_pkg::MODE_RANGE, 32'd2);
        send_item(xsrng_pkg::MODE_RANGE, '1);
        send_item(xsrng_pkg::MODE_RANGE, 32'h8000_0000);
        send_item(xsrng_pkg::MODE_RANGE, 32'h8000_0001);
        send_item(xsrng_pkg::MODE_RANGE, 32'haaaa_aaaa);
        send_item(xsrng_pkg::MODE_RANGE, 32'h5555_5555);
        send_item(MODE_SPARE, '1);
        send_item(MODE_SPARE, '0);
        await_results();

        // Seed zero scrambles to zero and loads the golden constant
        write_seed('0);
        send_item(xsrng_pkg::MODE_RAW, '0);
        send_item(xsrng_pkg::MODE_UPPER, '1);
        send_item(xsrng_pkg::MODE_RANGE, 32'd7);
        await_results();

        write_seed('1);
        send_item(xsrng_pkg::MODE_RAW, '1);
        send_item(xsrng_pkg::MODE_RANGE, '1);
        send_item(xsrng_pkg::MODE_RANGE, 32'd3);
        await_results();

        // Random phases, each under its own seed
        for (int phase = 0; phase < PHASES; phase++) begin
            case (phase)
                1:       seed_val = 64'h8000_0000_0000_0000;
                5:       seed_val = 64'd1;
                default: seed_val = {$urandom, $urandom};
            endcase
            write_seed(seed_val);
            steady  <= (phase == 1) || (phase == 4);
            hold_go <= (phase == 3);
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                r = $urandom_range(0, 99);
                if (r < 30)      mode_sel = xsrng_pkg::MODE_RAW;
                else if (r < 55) mode_sel = xsrng_pkg::MODE_UPPER;
                else if (r < 95) mode_sel = xsrng_pkg::MODE_RANGE;
                else             mode_sel = MODE_SPARE;
                case ($urandom_range(0, 9))
                    0:       bound_sel = '0;
                    1, 2:    bound_sel = $urandom_range(1, 20);
                    3:       bound_sel = 32'hffff_ffff - $urandom_range(0, 15);
                    4:       bound_sel = 32'd1 << $urandom_range(0, 31);
                    default: bound_sel = $urandom;
                endcase
                send_item(mode_sel, bound_sel);
                // Keep the sender busy through the hold-off phase
                if (phase != 3 && $urandom_range(0, 49) == 0) begin
                    await_results();
                end
            end
            await_results();
        end

        repeat (TAIL_CYCLES) @(posedge clk);
        if (fail_count == 0 && pending == 0) begin
            $display("** xorshift64star_bounded_rng: PASSED **");
        end else begin
            $display("** xorshift64star_bounded_rng: FAILED **");
        end
        $finish;
    end

endmodule
